// File: design/nus_pkg.sv
`timescale 1ns / 1ps
package nus_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TYPE_W     = 5;
  localparam int unsigned LEN_W      = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned ZR_W       = 2;

  // default width of the internal unit byte counter
  localparam int unsigned LENGTH_BITS_DEF = 20;

  // held byte plus up to four bytes taken in by one item
  localparam int unsigned SLOTS  = 5;
  localparam int unsigned SLOT_W = 3;

  localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;
  localparam logic [TYPE_W-1:0] TYPE_SEI   = 5'd6;

  localparam logic [ZR_W-1:0] ZR_SC_MIN = 2'd2;
  localparam logic [ZR_W-1:0] ZR_FULL   = 2'd3;

  localparam logic [LEN_W-1:0] LEN_MAX          = 20'hFFFFF;
  localparam logic [LEN_W-1:0] MAX_UNIT_RST     = 20'hFFFFF;
  localparam logic             DROP_SEI_RST     = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_UNIT_BYTES = 2'd0,
    REG_DROP_SEI       = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [TYPE_W-1:0] nal_type;
    logic              unit_start;
    logic              unit_end;
    logic [LEN_W-1:0]  unit_length;
    logic              oversize;
    logic              run_last;
  } result_t;

endpackage

// File: design/nus_byte_if.sv
`timescale 1ns / 1ps
interface nus_byte_if;
  logic                          valid;
  logic                          ready;
  logic [nus_pkg::BYTE_W-1:0]    data_byte;
  logic                          stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

// File: design/nus_cfg_if.sv
`timescale 1ns / 1ps
interface nus_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [nus_pkg::CFG_IDX_W-1:0]    index;
  logic [nus_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/nus_result_if.sv
`timescale 1ns / 1ps
interface nus_result_if;
  logic                          valid;
  logic                          ready;
  logic [nus_pkg::BYTE_W-1:0]    out_byte;
  logic [nus_pkg::TYPE_W-1:0]    nal_type;
  logic                          unit_start;
  logic                          unit_end;
  logic [nus_pkg::LEN_W-1:0]     unit_length;
  logic                          oversize;
  logic                          run_last;

  modport source (
    output valid, output out_byte, output nal_type, output unit_start,
    output unit_end, output unit_length, output oversize, output run_last,
    input ready
  );
  modport sink (
    input valid, input out_byte, input nal_type, input unit_start,
    input unit_end, input unit_length, input oversize, input run_last,
    output ready
  );
endinterface

// File: design/nus_parser.sv
`timescale 1ns / 1ps
module nus_parser #(
  parameter int unsigned LENGTH_BITS = nus_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [nus_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic                        stream_end_i,
  input  logic                        drop_sei_i,
  input  logic [nus_pkg::LEN_W-1:0]   max_unit_bytes_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output nus_pkg::result_t            res_o
);
  import nus_pkg::*;

  localparam int unsigned CW = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;

  // stream state
  logic [ZR_W-1:0]        zr_q, zr_d;
  logic                   hv_q, hv_d;
  logic [BYTE_W-1:0]      hb_q, hb_d;
  logic                   in_unit_q, in_unit_d;
  logic                   sup_q, sup_d;
  logic [TYPE_W-1:0]      type_q, type_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;

  // expansion record of one item
  logic                   rec_valid_q;
  logic [BYTE_W-1:0]      rec_bytes_q [SLOTS];
  logic [LENGTH_BITS-1:0] rec_cnt_q;
  logic [TYPE_W-1:0]      rec_type_q;
  logic [SLOT_W-1:0]      rec_ptr_q;
  logic [SLOT_W-1:0]      rec_last_q;
  logic                   rec_end_q;

  logic                   in_fire, res_fire;
  logic                   is_zero, is_sc, other;
  logic [SLOT_W-1:0]      k_main, k_all, k;
  logic [ZR_W-1:0]        zr_mid;
  logic                   end_step;
  logic [BYTE_W-1:0]      h [SLOTS];
  logic                   first_new;
  logic [TYPE_W-1:0]      t_new;
  logic                   s_new;
  logic [LENGTH_BITS:0]   cnt_sum;
  logic [LENGTH_BITS-1:0] cnt_after;
  logic [SLOT_W-1:0]      s_idx, e_idx;
  logic                   have;
  logic [LENGTH_BITS:0]   slot_sum;
  logic [LENGTH_BITS-1:0] slot_cnt;
  logic [CW-1:0]          slot_cnt_w, len_w;

  assign in_fire  = in_valid_i && in_ready_o;
  assign res_fire = rec_valid_q && res_ready_i;

  assign in_ready_o = !rec_valid_q || (res_ready_i && (rec_ptr_q == rec_last_q));

  assign is_zero = (data_byte_i == ZERO_BYTE);
  assign is_sc   = (data_byte_i == START_BYTE) && (zr_q >= ZR_SC_MIN);

  // bytes taken into the unit by this item, held zeros first
  always_comb begin
    other  = 1'b0;
    k_main = '0;
    zr_mid = '0;
    if (is_zero) begin
      if (zr_q == ZR_FULL) begin
        k_main = SLOT_W'(1);
        zr_mid = ZR_FULL;
      end else begin
        zr_mid = zr_q + ZR_W'(1);
      end
    end else if (!is_sc) begin
      other  = 1'b1;
      k_main = SLOT_W'(zr_q) + SLOT_W'(1);
    end
  end

  assign k_all    = k_main + (stream_end_i ? SLOT_W'(zr_mid) : '0);
  assign k        = in_unit_q ? k_all : '0;
  assign end_step = is_sc || stream_end_i;

  // held byte, then the new bytes; only the non-zero byte sits behind the zeros
  always_comb begin
    h[0] = hb_q;
    for (int j = 1; j < SLOTS; j++) begin
      h[j] = (other && (SLOT_W'(j - 1) == SLOT_W'(zr_q))) ? data_byte_i : ZERO_BYTE;
    end
  end

  assign first_new = (cnt_q == '0) && (k != '0);
  assign t_new     = first_new ? h[1][TYPE_W-1:0] : type_q;
  assign s_new     = first_new ? (drop_sei_i && (h[1][TYPE_W-1:0] == TYPE_SEI)) : sup_q;

  assign cnt_sum   = {1'b0, cnt_q} + (LENGTH_BITS + 1)'(k);
  assign cnt_after = cnt_sum[LENGTH_BITS] ? '1 : cnt_sum[LENGTH_BITS-1:0];

  // results run from the held byte (if any) to the last byte or the closing byte
  assign s_idx = hv_q ? '0 : SLOT_W'(1);
  assign e_idx = end_step ? k : (k - SLOT_W'(1));
  assign have  = !s_new && (end_step ? (hv_q || (k != '0)) : (k > s_idx));

  always_comb begin
    zr_d      = stream_end_i ? '0 : zr_mid;
    in_unit_d = stream_end_i ? 1'b0 : (is_sc || in_unit_q);
    hb_d      = (k != '0) ? h[k] : hb_q;
    if (end_step) begin
      hv_d   = 1'b0;
      cnt_d  = '0;
      sup_d  = 1'b0;
      type_d = '0;
    end else begin
      hv_d   = hv_q || (k != '0);
      cnt_d  = cnt_after;
      sup_d  = s_new;
      type_d = t_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zr_q      <= '0;
      hv_q      <= 1'b0;
      in_unit_q <= 1'b0;
      sup_q     <= 1'b0;
      type_q    <= '0;
      cnt_q     <= '0;
    end else if (in_fire) begin
      zr_q      <= zr_d;
      hv_q      <= hv_d;
      in_unit_q <= in_unit_d;
      sup_q     <= sup_d;
      type_q    <= type_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hb_q <= hb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= 1'b0;
      rec_ptr_q   <= '0;
      rec_last_q  <= '0;
      rec_end_q   <= 1'b0;
    end else if (in_fire && have) begin
      rec_valid_q <= 1'b1;
      rec_ptr_q   <= s_idx;
      rec_last_q  <= e_idx;
      rec_end_q   <= end_step;
    end else if (res_fire) begin
      if (rec_ptr_q == rec_last_q) begin
        rec_valid_q <= 1'b0;
      end else begin
        rec_ptr_q <= rec_ptr_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && have) begin
      rec_bytes_q <= h;
      rec_cnt_q   <= cnt_q;
      rec_type_q  <= t_new;
    end
  end

  // position of the slot's byte in its unit
  assign slot_sum   = {1'b0, rec_cnt_q} + (LENGTH_BITS + 1)'(rec_ptr_q);
  assign slot_cnt   = slot_sum[LENGTH_BITS] ? '1 : slot_sum[LENGTH_BITS-1:0];
  assign slot_cnt_w = CW'(slot_cnt);
  assign len_w      = (slot_cnt_w > CW'(LEN_MAX)) ? CW'(LEN_MAX) : slot_cnt_w;

  assign res_valid_o       = rec_valid_q;
  assign res_o.out_byte    = rec_bytes_q[rec_ptr_q];
  assign res_o.nal_type    = rec_type_q;
  assign res_o.unit_start  = (slot_cnt == LENGTH_BITS'(1));
  assign res_o.unit_end    = rec_end_q && (rec_ptr_q == rec_last_q);
  assign res_o.unit_length = len_w[LEN_W-1:0];
  assign res_o.oversize    = slot_cnt_w > CW'(max_unit_bytes_i);
  assign res_o.run_last    = (rec_ptr_q == rec_last_q);

endmodule

// File: design/nal_unit_splitter.sv
`timescale 1ns / 1ps
// nal unit splitter: annex b byte stream in, nal unit payload bytes out, one byte per item
// path: a byte's results are registered in the expansion record, then in the output register
// throughput: one byte per cycle while each byte yields at most one result and the output
//   is not stalled; a byte yielding more (up to 5, when held zeros are released) holds the
//   input until the expansion record drains its results, one per cycle as taken
// reset: asynchronous, active low; clears stream state, max_unit_bytes 1048575, drop_sei on
module nal_unit_splitter #(
  parameter int unsigned LENGTH_BITS = nus_pkg::LENGTH_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  nus_byte_if.sink      byte_i,
  nus_cfg_if.sink       cfg_i,
  nus_result_if.source  result_o
);
  import nus_pkg::*;

  // configuration registers
  logic [LEN_W-1:0] max_q;
  logic             drop_q;

  // parser to output register
  logic    res_valid;
  logic    res_ready;
  result_t res;

  // output register, parts the parser from the downstream stall
  logic    out_valid_q;
  result_t out_q;

  // config writes are always taken; the user must write only while no item is in flight (not enforced)
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= MAX_UNIT_RST;
      drop_q <= DROP_SEI_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_MAX_UNIT_BYTES: max_q  <= cfg_i.data[LEN_W-1:0];
        REG_DROP_SEI:       drop_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // start code search, zero holdback and per-item expansion
  nus_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (byte_i.valid),
    .in_ready_o       (byte_i.ready),
    .data_byte_i      (byte_i.data_byte),
    .stream_end_i     (byte_i.stream_end),
    .drop_sei_i       (drop_q),
    .max_unit_bytes_i (max_q),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_o            (res)
  );

  // load a new result whenever the register is empty or being emptied
  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.out_byte    = out_q.out_byte;
  assign result_o.nal_type    = out_q.nal_type;
  assign result_o.unit_start  = out_q.unit_start;
  assign result_o.unit_end    = out_q.unit_end;
  assign result_o.unit_length = out_q.unit_length;
  assign result_o.oversize    = out_q.oversize;
  assign result_o.run_last    = out_q.run_last;

`ifndef SYNTHESIS
  // a result blocked at the output register must hold off new stream bytes
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |-> !byte_i.ready)
    else $error("byte accepted while a pending result is stalled");

  // a unit's first byte always sits at position one
  a_start_len_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.unit_start |-> result_o.unit_length == LEN_W'(1))
    else $error("unit_start with length other than one");

  // a result without the oversize flag never has a length above the limit
  a_oversize_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.oversize |-> result_o.unit_length <= max_q)
    else $error("length above limit without oversize");
`endif

endmodule
